/* hw/rtl/lphj_pkg.sv */
// ----------------------------------------------------------------------------
// lphj_pkg
// Shared types and constants of the hash join table.
// ----------------------------------------------------------------------------
`default_nettype none

package lphj_pkg;

  localparam int unsigned SLOTS_LOG2_DEF = 10;
  localparam logic [63:0] FACTOR_RESET   = 64'd123456789123456789;
  localparam logic [63:0] EMPTY_KEY      = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [3:0]  USED_LG_RESET  = 4'd10;

  localparam logic REG_MULT    = 1'b0;
  localparam logic REG_USED_LG = 1'b1;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_PROBE  = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_RESERVED = 2'd2,
    ST_DONE     = 2'd3
  } status_t;

  typedef struct packed {
    logic cap;
    logic hash;
    logic sweep;
    logic rd;
    logic eval;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic is_clear;
    logic walk;
    logic stop;
    logic sweep_last;
  } sts_t;

endpackage

`default_nettype wire

/* hw/rtl/lphj_datapath.sv */
// ----------------------------------------------------------------------------
// lphj_datapath
// Slot memories, hash, probe walk registers, running total and result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module lphj_datapath #(
  parameter int unsigned SLOTS_LOG2 = lphj_pkg::SLOTS_LOG2_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [63:0]           cfg_data,
  input  wire logic [1:0]            in_opcode,
  input  wire logic [63:0]           in_key,
  input  wire logic [63:0]           in_payload,
  input  wire logic                  in_last,
  input  wire lphj_pkg::cmd_t        cmd,
  output lphj_pkg::sts_t             sts,
  output logic [1:0]                 out_status,
  output logic [10:0]                out_match_count,
  output logic [63:0]                out_match_pay,
  output logic [9:0]                 out_slot_index,
  output logic [63:0]                out_total_count,
  output logic                       out_batch_end
);
  import lphj_pkg::*;

  localparam int unsigned SLOTS = 1 << SLOTS_LOG2;
  localparam int unsigned SL    = SLOTS_LOG2;

  logic [63:0]   key_mem [SLOTS];
  logic [63:0]   pay_mem [SLOTS];

  logic [63:0]   mult;
  logic [3:0]    used_lg;
  op_t           op;
  logic [63:0]   key;
  logic [63:0]   payload;
  logic          last;
  logic [SL-1:0] pos;
  logic [SL-1:0] walk_n;
  logic [SL:0]   count;
  logic [63:0]   found;
  logic [SL-1:0] slot;
  status_t       status;
  logic [63:0]   total;
  logic [63:0]   rd_key;
  logic [63:0]   rd_pay;
  logic [SL-1:0] clr_addr;

  logic [SL-1:0]   mask;
  logic [2*SL-1:0] prod;
  logic [63:0]     total_next;
  logic            slot_empty;
  logic            mem_we;
  logic [SL-1:0]   mem_addr;
  logic [63:0]     mem_key;

  always_comb begin
    if (32'(used_lg) > SL) begin
      mask = '1;
    end else begin
      mask = ~({SL{1'b1}} << used_lg);
    end
  end

  assign prod       = key[SL-1:0] * mult[SL-1:0];
  assign slot_empty = (rd_key == EMPTY_KEY);

  assign sts.is_clear   = (op == OP_CLEAR);
  assign sts.walk       = ((op == OP_INSERT) || (op == OP_PROBE)) && (key != EMPTY_KEY);
  assign sts.stop       = slot_empty || (walk_n == mask);
  assign sts.sweep_last = &clr_addr;

  always_comb begin
    mem_we   = 1'b0;
    mem_addr = pos;
    mem_key  = key;
    if (cmd.sweep) begin
      mem_we   = 1'b1;
      mem_addr = clr_addr;
      mem_key  = EMPTY_KEY;
    end else if (cmd.eval && (op == OP_INSERT) && slot_empty) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[mem_addr] <= mem_key;
    end
    if (mem_we && !cmd.sweep) begin
      pay_mem[mem_addr] <= payload;
    end
    if (cmd.rd) begin
      rd_key <= key_mem[pos];
      rd_pay <= pay_mem[pos];
    end
  end

  always_comb begin
    unique case (op)
      OP_PROBE: total_next = total + 64'(count);
      OP_CLEAR: total_next = '0;
      default:  total_next = total;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mult     <= FACTOR_RESET;
      used_lg  <= USED_LG_RESET;
      op       <= OP_NOP;
      total    <= '0;
      clr_addr <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MULT:    mult    <= cfg_data;
          REG_USED_LG: used_lg <= cfg_data[3:0];
          default:     mult    <= mult;
        endcase
      end
      if (cmd.cap) begin
        op <= op_t'(in_opcode);
      end
      if (cmd.sweep) begin
        clr_addr <= clr_addr + SL'(1);
      end
      if (cmd.emit) begin
        total <= total_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      key     <= in_key;
      payload <= in_payload;
      last    <= in_last;
    end
    if (cmd.hash) begin
      pos    <= prod[SL-1:0] & mask;
      walk_n <= '0;
      count  <= '0;
      found  <= '0;
      slot   <= '0;
      if (op == OP_INSERT) begin
        status <= (key == EMPTY_KEY) ? ST_RESERVED : ST_FULL;
      end else begin
        status <= ST_DONE;
      end
    end
    if (cmd.eval) begin
      pos    <= (pos + SL'(1)) & mask;
      walk_n <= walk_n + SL'(1);
      if (op == OP_INSERT) begin
        if (slot_empty) begin
          status <= ST_INSERTED;
          slot   <= pos;
        end
      end else if (!slot_empty && (rd_key == key)) begin
        count <= count + (SL + 1)'(1);
        found <= rd_pay;
        slot  <= pos;
      end
    end
    if (cmd.emit) begin
      out_status      <= status;
      out_match_count <= 11'(count);
      out_match_pay   <= found;
      out_slot_index  <= 10'(slot);
      out_total_count <= total_next;
      out_batch_end   <= last;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    cmd.eval |-> (walk_n <= mask))
    else $error("probe walk passed the used slots");

endmodule

`default_nettype wire

/* hw/rtl/lphj_ctrl.sv */
// ----------------------------------------------------------------------------
// lphj_ctrl
// Sequencer: clearing sweep, hash, slot read and check loop, result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module lphj_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire lphj_pkg::sts_t sts,
  output lphj_pkg::cmd_t      cmd
);
  import lphj_pkg::*;

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_HASH,
    S_READ,
    S_CHECK,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) begin
          state_next = sts.is_clear ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap    = 1'b1;
          state_next = S_HASH;
        end
      end
      S_HASH: begin
        cmd.hash = 1'b1;
        if (sts.is_clear) begin
          state_next = S_SWEEP;
        end else if (sts.walk) begin
          state_next = S_READ;
        end else begin
          state_next = S_DONE;
        end
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        cmd.eval   = 1'b1;
        state_next = sts.stop ? S_DONE : S_READ;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_SWEEP;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/linear_probe_hash_join_table.sv */
// ----------------------------------------------------------------------------
// linear_probe_hash_join_table
// Hash join build and probe table with linear probing.
//
// Input beats carry an opcode in s_tuser (insert, probe, clear, no-op), key
// and payload in s_tdata and the batch mark in s_tlast. Each input beat gives
// one result beat: status in m_tuser, counts, payload, slot and running total
// in m_tdata, batch mark echoed on m_tlast. Configuration writes on cfg_*:
// index 0 hash multiplier, index 1 log2 of slots in use; write only when idle.
// One item at a time: an insert or probe is captured, hashed, then reads and
// checks one visited slot after another (one memory read, one check each)
// until an empty slot or the end of the used slots. Reserved keys and no-ops
// skip the slot walk. Clear sweeps every slot, one per cycle.
// After reset the same sweep runs over every slot before s_tready
// rises. The result sits in an output register; a stalled receiver holds the
// beat, and the next item is taken and worked while it waits, stalling only
// when its own result is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_probe_hash_join_table #(
  parameter int unsigned SLOTS_LOG2 = lphj_pkg::SLOTS_LOG2_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic         cfg_index,
  input  wire logic [63:0]  cfg_data,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [127:0] s_tdata,   // key[63:0], payload[127:64]
  input  wire logic [1:0]   s_tuser,   // opcode[1:0]
  input  wire logic         s_tlast,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [151:0]      m_tdata,   // match_count[10:0], match_pay[74:11],
                                       // slot_index[84:75], total_count[148:85]
  output logic [1:0]        m_tuser,   // status[1:0]
  output logic              m_tlast
);
  import lphj_pkg::*;

  cmd_t        cmd;
  sts_t        sts;
  logic [10:0] match_count;
  logic [63:0] match_pay;
  logic [9:0]  slot_index;
  logic [63:0] total_count;

  assign cfg_ready = 1'b1;
  assign m_tdata   = {3'b000, total_count, slot_index, match_pay, match_count};

  lphj_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lphj_datapath #(
    .SLOTS_LOG2 (SLOTS_LOG2)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_opcode       (s_tuser),
    .in_key          (s_tdata[63:0]),
    .in_payload      (s_tdata[127:64]),
    .in_last         (s_tlast),
    .cmd             (cmd),
    .sts             (sts),
    .out_status      (m_tuser),
    .out_match_count (match_count),
    .out_match_pay   (match_pay),
    .out_slot_index  (slot_index),
    .out_total_count (total_count),
    .out_batch_end   (m_tlast)
  );

  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second item taken while one is in work");

  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cmd.emit))
    else $error("result beat without emit");

  assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !(cmd.rd || cmd.eval || cmd.sweep || cmd.cap))
    else $error("emit overlaps other work");

endmodule

`default_nettype wire
